[hw/rtl/rvp_pkg.sv]
// Shared constants, codes and types of the RTP video packetizer.
`timescale 1ns / 1ps
`default_nettype none

package rvp_pkg;

  // Payload bytes per packet (range 64 to 2047)
  localparam int unsigned PACKET_PAYLOAD = 1400;

  localparam int unsigned LEN_W  = 20;
  localparam int unsigned FILL_W = 11;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [LEN_W-1:0]  WHOLE_MAX = LEN_W'(PACKET_PAYLOAD - 3);
  localparam logic [LEN_W-1:0]  CHUNK_LEN = LEN_W'(PACKET_PAYLOAD);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(PACKET_PAYLOAD);

  // Sequence counter: the value after 65534 is 0
  localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(65535 - 1);

  // FU preamble fields
  localparam logic [7:0] FUA_TYPE     = 8'd28;
  localparam logic [7:0] HEVC_FU_TYPE = 8'(49 << 1);
  localparam logic [7:0] H264_NRI     = 8'hE0;
  localparam logic [7:0] H264_TYPE    = 8'h1F;
  localparam logic [7:0] HEVC_KEEP    = 8'h81;
  localparam logic [7:0] FU_S_BIT     = 8'h80;
  localparam logic [7:0] FU_E_BIT     = 8'h40;

  // Result queue
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);
  localparam int unsigned PUSH_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEVEL_W-1:0] ACCEPT_LEVEL = LEVEL_W'(QUEUE_DEPTH - MAX_RESULTS);

  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_H264 = 2'd1,
    MODE_H265 = 2'd2
  } codec_t;

  typedef enum logic [1:0] {
    REG_CODEC  = 2'd0,
    REG_PTYPE  = 2'd1,
    REG_SOURCE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  codec_mode;
    logic [6:0]  payload_type;
    logic [31:0] stream_source_id;
  } rvp_cfg_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             unit_start;
    logic [LEN_W-1:0] unit_length;
    logic             final_unit;
    logic [31:0]      frame_time;
  } rvp_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             packet_first;
    logic             packet_last;
    logic             marker_bit;
    logic [SEQ_W-1:0] sequence_number;
    logic [31:0]      header_time;
    logic [6:0]       header_type;
    logic [31:0]      header_source;
  } rvp_result_t;

  typedef struct packed {
    rvp_result_t [MAX_RESULTS-1:0] item;
    logic [PUSH_W-1:0]             count;
  } rvp_push_t;

endpackage

`default_nettype wire

[hw/rtl/rvp_if.sv]
// Valid/ready channel interfaces for unit bytes in and packet bytes out.
`timescale 1ns / 1ps
`default_nettype none

interface rvp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        unit_start;
  logic [19:0] unit_length;
  logic        final_unit;
  logic [31:0] frame_time;

  modport source (
    output valid, data_byte, unit_start, unit_length, final_unit, frame_time,
    input  ready
  );
  modport sink (
    input  valid, data_byte, unit_start, unit_length, final_unit, frame_time,
    output ready
  );
endinterface

interface rvp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        packet_first;
  logic        packet_last;
  logic        marker_bit;
  logic [15:0] sequence_number;
  logic [31:0] header_time;
  logic [6:0]  header_type;
  logic [31:0] header_source;

  modport source (
    output valid, out_byte, packet_first, packet_last, marker_bit, sequence_number,
           header_time, header_type, header_source,
    input  ready
  );
  modport sink (
    input  valid, out_byte, packet_first, packet_last, marker_bit, sequence_number,
           header_time, header_type, header_source,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/rvp_regs.sv]
// APB configuration registers: codec mode, payload type, SSRC.
`timescale 1ns / 1ps
`default_nettype none

module rvp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rvp_pkg::ADDR_W-1:0]  paddr,
  input  logic [rvp_pkg::DATA_W-1:0]  pwdata,
  output logic [rvp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rvp_pkg::rvp_cfg_t           cfg
);
  import rvp_pkg::*;

  logic                wr_en;
  logic [ADDR_W-3:0]   index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign index  = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.codec_mode       <= MODE_H264;
      cfg.payload_type     <= 7'd96;
      cfg.stream_source_id <= '0;
    end else if (wr_en) begin
      unique case (index)
        REG_CODEC:  cfg.codec_mode       <= pwdata[1:0];
        REG_PTYPE:  cfg.payload_type     <= pwdata[6:0];
        REG_SOURCE: cfg.stream_source_id <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_CODEC:  prdata = DATA_W'(cfg.codec_mode);
      REG_PTYPE:  prdata = DATA_W'(cfg.payload_type);
      REG_SOURCE: prdata = cfg.stream_source_id;
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/rvp_engine.sv]
// Unit state and packet cutting: turns one accepted byte into 0, 1, 3 or 4 results.
`timescale 1ns / 1ps
`default_nettype none

module rvp_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  rvp_pkg::rvp_item_t item,
  input  rvp_pkg::rvp_cfg_t  cfg,
  output rvp_pkg::rvp_push_t push
);
  import rvp_pkg::*;

  // unit state
  logic [SEQ_W-1:0]  sequence_counter, sequence_counter_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [FILL_W-1:0] fragment_fill, fragment_fill_next;
  logic              fragmenting, fragmenting_next;
  logic              first_fragment, first_fragment_next;
  logic [7:0]        unit_header, unit_header_next;
  logic [7:0]        unit_header2, unit_header2_next;
  logic [1:0]        header_skip, header_skip_next;
  logic [31:0]       held_time, held_time_next;
  logic              held_final, held_final_next;
  logic              packet_marker, packet_marker_next;
  codec_t            unit_mode, unit_mode_next;

  // working values
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  left_dec;
  logic [FILL_W-1:0] fill_inc;
  logic              fu_end;
  logic              last;
  logic [7:0]        se_bits;
  logic [SLOT_W-1:0] slot;
  logic [7:0]        byte_v  [MAX_RESULTS];
  logic              first_v [MAX_RESULTS];
  logic              last_v  [MAX_RESULTS];

  always_comb begin
    // unit start reloads the unit state before the byte is handled
    unit_mode_next        = unit_mode;
    held_time_next        = held_time;
    held_final_next       = held_final;
    bytes_left_next       = bytes_left;
    fragment_fill_next    = fragment_fill;
    first_fragment_next   = first_fragment;
    fragmenting_next      = fragmenting;
    header_skip_next      = header_skip;
    unit_header_next      = unit_header;
    unit_header2_next     = unit_header2;
    sequence_counter_next = sequence_counter;
    packet_marker_next    = packet_marker;
    len                   = (item.unit_length == '0) ? LEN_W'(1) : item.unit_length;
    left_dec              = '0;
    fill_inc              = '0;
    fu_end                = 1'b0;
    last                  = 1'b0;
    se_bits               = '0;
    slot                  = '0;
    push.count            = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      byte_v[k]  = '0;
      first_v[k] = 1'b0;
      last_v[k]  = 1'b0;
    end

    if (item.unit_start) begin
      if (cfg.codec_mode == MODE_H264) begin
        unit_mode_next = MODE_H264;
      end else if (cfg.codec_mode == MODE_H265) begin
        unit_mode_next = MODE_H265;
      end else begin
        unit_mode_next = MODE_RAW;
      end
      held_time_next      = item.frame_time;
      held_final_next     = item.final_unit;
      bytes_left_next     = len;
      fragment_fill_next  = '0;
      first_fragment_next = 1'b1;
      fragmenting_next    = (unit_mode_next != MODE_RAW) && (len > WHOLE_MAX);
      header_skip_next    = !fragmenting_next ? 2'd0 :
                            (unit_mode_next == MODE_H265) ? 2'd2 : 2'd1;
    end

    if (bytes_left_next != '0) begin
      if (header_skip_next != 2'd0) begin
        // NAL header bytes are kept for the FU preamble, not sent
        if (unit_mode_next == MODE_H265 && header_skip_next == 2'd1) begin
          unit_header2_next = item.data_byte;
        end else begin
          unit_header_next = item.data_byte;
        end
        header_skip_next = header_skip_next - 2'd1;
        bytes_left_next  = bytes_left_next - LEN_W'(1);
      end else begin
        if (fragment_fill_next == '0) begin
          sequence_counter_next = (sequence_counter >= SEQ_LAST) ? '0 :
                                  sequence_counter + SEQ_W'(1);
          if (fragmenting_next) begin
            fu_end  = bytes_left_next <= CHUNK_LEN;
            se_bits = first_fragment_next ? FU_S_BIT : (fu_end ? FU_E_BIT : 8'h00);
            packet_marker_next = fu_end && held_final_next;
            first_v[0] = 1'b1;
            if (unit_mode_next == MODE_H265) begin
              byte_v[0] = (unit_header_next & HEVC_KEEP) | HEVC_FU_TYPE;
              byte_v[1] = unit_header2_next;
              byte_v[2] = {2'b00, unit_header_next[6:1]} | se_bits;
              slot      = SLOT_W'(3);
            end else begin
              byte_v[0] = (unit_header_next & H264_NRI) | FUA_TYPE;
              byte_v[1] = (unit_header_next & H264_TYPE) | se_bits;
              slot      = SLOT_W'(2);
            end
            first_fragment_next = 1'b0;
          end else if (unit_mode_next == MODE_RAW) begin
            packet_marker_next = bytes_left_next < CHUNK_LEN;
          end else begin
            packet_marker_next = held_final_next;
          end
        end
        fill_inc = fragment_fill_next + FILL_W'(1);
        left_dec = bytes_left_next - LEN_W'(1);
        last     = (fill_inc >= FILL_MAX) || (left_dec == '0);
        byte_v[slot]  = item.data_byte;
        first_v[slot] = (fragment_fill_next == '0) && !fragmenting_next;
        last_v[slot]  = last;
        fragment_fill_next = last ? '0 : fill_inc;
        bytes_left_next    = left_dec;
        push.count         = PUSH_W'(slot) + PUSH_W'(1);
      end
    end

    if (!accept) begin
      push.count = '0;
    end

    for (int k = 0; k < MAX_RESULTS; k++) begin
      push.item[k].out_byte        = byte_v[k];
      push.item[k].packet_first    = first_v[k];
      push.item[k].packet_last     = last_v[k];
      push.item[k].marker_bit      = packet_marker_next;
      push.item[k].sequence_number = sequence_counter_next;
      push.item[k].header_time     = held_time_next;
      push.item[k].header_type     = cfg.payload_type;
      push.item[k].header_source   = cfg.stream_source_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter <= '0;
      bytes_left       <= '0;
      fragment_fill    <= '0;
      fragmenting      <= 1'b0;
      first_fragment   <= 1'b0;
      unit_header      <= '0;
      unit_header2     <= '0;
      header_skip      <= '0;
      held_time        <= '0;
      held_final       <= 1'b0;
      packet_marker    <= 1'b0;
      unit_mode        <= MODE_RAW;
    end else if (accept) begin
      sequence_counter <= sequence_counter_next;
      bytes_left       <= bytes_left_next;
      fragment_fill    <= fragment_fill_next;
      fragmenting      <= fragmenting_next;
      first_fragment   <= first_fragment_next;
      unit_header      <= unit_header_next;
      unit_header2     <= unit_header2_next;
      header_skip      <= header_skip_next;
      held_time        <= held_time_next;
      held_final       <= held_final_next;
      packet_marker    <= packet_marker_next;
      unit_mode        <= unit_mode_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rvp_queue.sv]
// Result queue: takes up to four results per cycle, gives one per cycle while pop is high.
`timescale 1ns / 1ps
`default_nettype none

module rvp_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  rvp_pkg::rvp_push_t           push,
  input  logic                         pop,
  output rvp_pkg::rvp_result_t         head,
  output logic [rvp_pkg::LEVEL_W-1:0]  level
);
  import rvp_pkg::*;

  rvp_result_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] offset [QUEUE_DEPTH];

  // distance of each entry from the write pointer picks its push slot
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      offset[i] = QPTR_W'(i) - wr_ptr;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (PUSH_W'(offset[i]) < push.count) begin
        entries[i] <= push.item[offset[i][SLOT_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      level  <= level + LEVEL_W'(push.count) - LEVEL_W'(pop);
    end
  end

  assign head = entries[rd_ptr];

endmodule

`default_nettype wire

[hw/rtl/rtp_video_packetizer_core.sv]
// Top level of the RTP video packetizer: unit bytes in, packet payload bytes out.
//
//  channel  | dir | handshake        | carries
//  ---------+-----+------------------+-----------------------------------------------
//  in_ch    | in  | valid/ready      | data_byte, unit_start, unit_length, final_unit,
//           |     |                  | frame_time
//  out_ch   | out | valid/ready      | out_byte, packet_first/last, marker_bit,
//           |     |                  | sequence_number, header_time/type/source
//  APB      | in  | psel/penable     | codec_mode @0x0, payload_type @0x4, SSRC @0x8
//
// Cycles: an input transfer is handled in the cycle it is taken; its results land
//   in an 8-entry result queue at that edge and leave one per cycle on out_ch while out_ch.ready is high.
// Rate: one byte per cycle for plain packet bytes while in_ch is ready. The first
//   byte of an FU packet gives 3 (H.264) or 4 (H.265) output transfers, so the output
//   port sets the pace there and in_ch stalls while the queue has fewer than 4 free entries.
// Reset (rst, synchronous): queue empty, unit state and sequence counter cleared,
//   registers to codec 1, payload type 96, SSRC 0.
// Stalls on out_ch fill the queue; in_ch keeps taking bytes until fewer than 4
//   entries are free.
`timescale 1ns / 1ps
`default_nettype none

module rtp_video_packetizer_core (
  input  logic                        clk,
  input  logic                        rst,
  rvp_in_if.sink                      in_ch,
  rvp_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rvp_pkg::ADDR_W-1:0]  paddr,
  input  logic [rvp_pkg::DATA_W-1:0]  pwdata,
  output logic [rvp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rvp_pkg::*;

  rvp_cfg_t           cfg;
  rvp_item_t          item;
  rvp_push_t          push;
  rvp_result_t        head;
  logic [LEVEL_W-1:0] level;
  logic               accept;
  logic               pop;

  rvp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // room for the largest burst of results decides whether a byte is taken
  assign in_ch.ready = (level <= ACCEPT_LEVEL);
  assign accept      = in_ch.valid && in_ch.ready;

  assign item.data_byte   = in_ch.data_byte;
  assign item.unit_start  = in_ch.unit_start;
  assign item.unit_length = in_ch.unit_length;
  assign item.final_unit  = in_ch.final_unit;
  assign item.frame_time  = in_ch.frame_time;

  rvp_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .push   (push)
  );

  assign out_ch.valid = (level != '0);
  assign pop          = out_ch.valid && out_ch.ready;

  rvp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  assign out_ch.out_byte        = head.out_byte;
  assign out_ch.packet_first    = head.packet_first;
  assign out_ch.packet_last     = head.packet_last;
  assign out_ch.marker_bit      = head.marker_bit;
  assign out_ch.sequence_number = head.sequence_number;
  assign out_ch.header_time     = head.header_time;
  assign out_ch.header_type     = head.header_type;
  assign out_ch.header_source   = head.header_source;

  // a byte yields no result, one, or a 2- or 3-byte FU preamble plus one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push.count == PUSH_W'(0)) || (push.count == PUSH_W'(1)) ||
    (push.count == PUSH_W'(3)) || (push.count == PUSH_W'(4)))
    else $error("bad result count from engine");

  // the queue never holds more than it has entries
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // a preamble burst always opens a packet
  a_preamble_first: assert property (@(posedge clk) disable iff (rst)
    (push.count >= PUSH_W'(3)) |-> push.item[0].packet_first)
    else $error("FU preamble without packet_first");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
